@@ rtl/core/utf8v_pkg.sv @@
`default_nettype none

package utf8v_pkg;

  // Default width of the saturating character counter.
  localparam int COUNT_WIDTH_DEF = 16;

  // Widths of the result fields and of the packed result word.
  localparam int STATUS_W   = 2;
  localparam int CHAR_W     = 16;
  localparam int OUT_DATA_W = 24;

  // Status codes, in order of the field encoding.
  localparam logic [STATUS_W-1:0] ST_VALID    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BADSEQ   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERLONG = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BADCP    = 2'd3;

  // Codepoint limits.
  localparam logic [20:0] CP_MAX       = 21'h10FFFF;
  localparam logic [20:0] CP_SURR_LO   = 21'h00D800;
  localparam logic [20:0] CP_SURR_HI   = 21'h00DFFF;
  localparam logic [20:0] CP_MIN_LEN2  = 21'h000080;
  localparam logic [20:0] CP_MIN_LEN3  = 21'h000800;
  localparam logic [20:0] CP_MIN_LEN4  = 21'h010000;

  // Decoder state carried from one byte to the next.
  typedef struct packed {
    logic [1:0]          rem;
    logic [2:0]          seq_len;
    logic [20:0]         acc;
    logic [STATUS_W-1:0] err;
  } dec_state_t;

endpackage

`default_nettype wire

@@ rtl/core/utf8v_dec.sv @@
`default_nettype none

module utf8v_dec
  import utf8v_pkg::*;
(
  input  dec_state_t cur,
  input  logic [7:0] data_byte,
  output dec_state_t nxt
);

  logic [20:0] acc_sh;
  logic [1:0]  rem_dec;
  logic        is_cont;

  assign acc_sh  = {cur.acc[14:0], data_byte[5:0]};
  assign rem_dec = cur.rem - 2'd1;
  assign is_cont = (data_byte[7:6] == 2'b10);

  // One byte of decoding. Once an error is held, the state freezes.
  always_comb begin
    nxt = cur;
    if (cur.err == ST_VALID) begin
      if (cur.rem == 2'd0) begin
        // Expecting a lead byte.
        if (data_byte[7] == 1'b0) begin
          nxt.acc     = {13'd0, data_byte};
          nxt.seq_len = 3'd0;
        end else if (data_byte[7:5] == 3'b110) begin
          nxt.acc     = {16'd0, data_byte[4:0]};
          nxt.seq_len = 3'd2;
          nxt.rem     = 2'd1;
        end else if (data_byte[7:4] == 4'b1110) begin
          nxt.acc     = {17'd0, data_byte[3:0]};
          nxt.seq_len = 3'd3;
          nxt.rem     = 2'd2;
        end else if (data_byte[7:3] == 5'b11110) begin
          nxt.acc     = {18'd0, data_byte[2:0]};
          nxt.seq_len = 3'd4;
          nxt.rem     = 2'd3;
        end else begin
          nxt.err = ST_BADSEQ;
        end
      end else if (!is_cont) begin
        // A continuation was due but something else arrived.
        nxt.err     = ST_BADSEQ;
        nxt.rem     = 2'd0;
        nxt.seq_len = 3'd0;
      end else begin
        nxt.acc = acc_sh;
        nxt.rem = rem_dec;
        if (rem_dec == 2'd0) begin
          // Sequence complete: overlong form first, then the value range.
          if ((cur.seq_len == 3'd2 && acc_sh < CP_MIN_LEN2) ||
              (cur.seq_len == 3'd3 && acc_sh < CP_MIN_LEN3) ||
              (cur.seq_len == 3'd4 && acc_sh < CP_MIN_LEN4)) begin
            nxt.err = ST_OVERLONG;
          end else if (acc_sh > CP_MAX ||
                       (acc_sh >= CP_SURR_LO && acc_sh <= CP_SURR_HI)) begin
            nxt.err = ST_BADCP;
          end
          nxt.seq_len = 3'd0;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/utf8_stream_validator.sv @@
// UTF-8 stream validator.
// The input channel (in_*) carries one byte of a buffer per item in
// in_tdata[7:0]; in_tlast marks the final byte of the buffer. For every
// buffer one result item leaves on the output channel (out_*) after its final
// byte: out_tdata[1:0] is the status (valid, invalid sequence, overlong
// encoding, invalid codepoint) and out_tdata[17:2] the count of bytes that
// are not continuation bytes, saturating. The first error in a buffer sticks.
// Throughput is one byte per cycle unless a final byte waits on a pending
// result. A byte passes an input register and then the decoder, which updates
// the state and loads the result register, so a result is valid once its final
// byte has passed the input register and the result register.
// Decoder state and counter clear after each final byte, ready for the next buffer.
// Synchronous reset clears the state and drops both valid flags.
// While the receiver stalls with a result pending, ordinary bytes keep
// flowing; only a final byte waits in the input register, and in_tready
// drops until the pending result is taken.
`default_nettype none

module utf8_stream_validator
  import utf8v_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // in_tdata: [7:0] data_byte
  input  wire logic [7:0]            in_tdata,
  input  wire logic                  in_tlast,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // out_tdata: [1:0] status, [17:2] lead_total, [23:18] zero
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready
);

  logic                       in_valid_r;
  logic [7:0]                 in_byte_r;
  logic                       in_last_r;
  logic                       advance;

  dec_state_t                 dec_r;
  dec_state_t                 dec_nxt;
  logic [COUNT_WIDTH-1:0]     cnt_r;
  logic [COUNT_WIDTH-1:0]     cnt_nxt;
  logic [COUNT_WIDTH+CHAR_W-1:0] cnt_ext;
  logic [STATUS_W-1:0]        status_fin;

  logic                       out_valid_r;
  logic [STATUS_W-1:0]        out_status_r;
  logic [CHAR_W-1:0]          out_count_r;

  // The held byte moves on unless it is a final byte blocked by a pending result.
  assign advance   = in_valid_r && (!in_last_r || !out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  utf8v_dec u_dec (
    .cur       (dec_r),
    .data_byte (in_byte_r),
    .nxt       (dec_nxt)
  );

  // Saturating count of non-continuation bytes.
  always_comb begin
    cnt_nxt = cnt_r;
    if (in_byte_r[7:6] != 2'b10 && cnt_r != {COUNT_WIDTH{1'b1}}) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  assign cnt_ext = {{CHAR_W{1'b0}}, cnt_nxt};

  // An open sequence at the final byte counts as truncation.
  assign status_fin = (dec_nxt.err == ST_VALID && dec_nxt.rem != 2'd0) ?
                      ST_BADSEQ : dec_nxt.err;

  // Decoder state and counter; both clear after a final byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_r <= '0;
      cnt_r <= '0;
    end else if (advance) begin
      if (in_last_r) begin
        dec_r <= '0;
        cnt_r <= '0;
      end else begin
        dec_r <= dec_nxt;
        cnt_r <= cnt_nxt;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && in_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last_r) begin
      out_status_r <= status_fin;
      out_count_r  <= cnt_ext[CHAR_W-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-CHAR_W-STATUS_W){1'b0}}, out_count_r, out_status_r};

endmodule

`default_nettype wire

@@ rtl/core/utf8v_checker.sv @@
`default_nettype none

module utf8v_checker
  import utf8v_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tvalid,
  input wire logic                  in_tready,
  input wire logic                  in_tlast,
  input wire logic [OUT_DATA_W-1:0] out_tdata,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Reset leaves no result pending and the input side open.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("block not idle after reset");

  // With no result blocked, the input side never stalls.
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid || out_tready) |-> in_tready)
    else $error("input stalled without a blocked result");

  // Pad bits of the result word stay zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_DATA_W-1:CHAR_W+STATUS_W] == '0)
    else $error("result pad bits not zero");

  // A final byte that goes in must be followed by a pending result once it has passed the input and result registers.
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |-> ##2 out_tvalid)
    else $error("no result after a final byte");

endmodule

bind utf8_stream_validator utf8v_checker u_utf8v_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

`default_nettype wire
